>>> sv/rcrp_pkg.sv
// Shared types, codes and helper functions of the replay command record parser.
package rcrp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TURNS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAPPED_LAYOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYERS_PRESENT = 2'd2;

    // Stream constants
    localparam logic [7:0] END_MARKER = 8'h80;
    localparam logic [2:0] LAST_POS_SHORT = 3'd3;
    localparam logic [2:0] LAST_POS_LONG  = 3'd4;
    localparam logic [3:0] MASK_RESET = 4'b0001;

    typedef enum logic [1:0] {
        KIND_RECORD     = 2'd0,
        KIND_RECORD_END = 2'd1,
        KIND_END_MARKER = 2'd2,
        KIND_DROPPED    = 2'd3
    } rcrp_kind_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [2:0] pos;
        logic [1:0] player;
        logic [7:0] fwd_hold;
        logic [7:0] side_hold;
        logic [7:0] turn_lo_hold;
        logic [7:0] turn_hi_hold;
    } rcrp_state_t;

    // One result beat
    typedef struct packed {
        rcrp_kind_t         kind;
        logic [1:0]         player;
        logic signed [7:0]  forward_move;
        logic signed [7:0]  side_move;
        logic signed [15:0] turn_amount;
        logic [7:0]         button_bits;
    } rcrp_result_t;

    // Mode bits handed to the step logic
    typedef struct packed {
        logic long_turns;
        logic swapped_layout;
        logic [3:0] players_present;
    } rcrp_cfg_t;

    // Lowest set bit of the mask; empty mask means player 0
    function automatic logic [1:0] lowest_present(input logic [3:0] mask);
        logic [1:0] res;
        res = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (mask[i])
            begin
                res = 2'(i);
            end
        end
        return res;
    endfunction

    // Next present player after cur, wrapping; empty mask means player 0
    function automatic logic [1:0] next_present(input logic [1:0] cur,
                                                input logic [3:0] mask);
        logic [1:0] res;
        logic [1:0] p;
        res = 2'd0;
        for (int k = 4; k >= 1; k--)
        begin
            p = cur + 2'(k);
            if (mask[p])
            begin
                res = p;
            end
        end
        return res;
    endfunction

endpackage

>>> sv/rcrp_if.sv
// Stream channel interfaces: command bytes in, command records out.
interface rcrp_in_if
    import rcrp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface rcrp_out_if
    import rcrp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         player;
    logic signed [7:0]  forward_move;
    logic signed [7:0]  side_move;
    logic signed [15:0] turn_amount;
    logic [7:0]         button_bits;

    modport source (output valid, output kind, output player, output forward_move,
                    output side_move, output turn_amount, output button_bits,
                    input ready);
    modport sink   (input valid, input kind, input player, input forward_move,
                    input side_move, input turn_amount, input button_bits,
                    output ready);
endinterface

>>> sv/replay_command_record_parser.sv
// Top level: replay command record parser, one command byte per beat.
// Latency: a result beat is valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the per-byte state update and one output register
// set this, and the input is held only while the output register is full and stalled.
// Reset (rst_n low, asynchronous): position 0, player 0, short turns, normal layout,
// presence mask 0001, output empty.
module replay_command_record_parser
    import rcrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rcrp_in_if.sink               in_ch,
    rcrp_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rcrp_cfg_t    cfg_reg;
    rcrp_state_t  state_reg;
    rcrp_state_t  state_next;
    rcrp_state_t  step_state;
    rcrp_result_t step_res;
    logic         step_emit;
    logic         out_free;
    logic         accept;
    logic         mask_wr;

    assign in_ch.ready = out_free;
    assign accept      = in_ch.valid && in_ch.ready;
    assign mask_wr     = cfg_we && (cfg_index == CFG_PLAYERS_PRESENT);

    rcrp_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .data_byte   (in_ch.data_byte),
        .end_of_data (in_ch.end_of_data),
        .nxt         (step_state),
        .emit        (step_emit),
        .res         (step_res)
    );

    rcrp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && step_emit),
        .load_res (step_res),
        .free     (out_free),
        .out_ch   (out_ch)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_turns      <= 1'b0;
            cfg_reg.swapped_layout  <= 1'b0;
            cfg_reg.players_present <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_TURNS:      cfg_reg.long_turns      <= cfg_data[0];
                CFG_SWAPPED_LAYOUT:  cfg_reg.swapped_layout  <= cfg_data[0];
                CFG_PLAYERS_PRESENT: cfg_reg.players_present <= cfg_data;
                default: ;
            endcase
        end
    end

    // next parser state; a mask write reloads the current player
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = step_state;
        end
        if (mask_wr)
        begin
            state_next.player = lowest_present(cfg_data);
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // position never runs past the long-mode final byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos <= LAST_POS_LONG)
        else $error("parser position out of range");

    // current player is one marked present whenever the mask is not empty
    a_player_present: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.players_present != 4'd0) |-> cfg_reg.players_present[state_reg.player])
        else $error("current player not present in mask");

    // any result beat restarts the record
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_emit && !mask_wr) |=> (state_reg.pos == 3'd0))
        else $error("record position not cleared after result");

    // a produced result appears on the output
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_emit) |=> out_ch.valid)
        else $error("result beat lost");

    // a byte without result advances the position by one
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !step_emit) |=> (state_reg.pos == $past(state_reg.pos) + 3'd1))
        else $error("position did not advance");

endmodule

>>> sv/rcrp_step.sv
// Per-byte parser step: next state and optional result for one command byte.
module rcrp_step
    import rcrp_pkg::*;
(
    input  rcrp_state_t  cur,
    input  rcrp_cfg_t    cfg,
    input  logic [7:0]   data_byte,
    input  logic         end_of_data,
    output rcrp_state_t  nxt,
    output logic         emit,
    output rcrp_result_t res
);

    logic [2:0]  last_pos;
    logic [15:0] turn_norm;
    logic [1:0]  first_player;

    assign last_pos     = cfg.long_turns ? LAST_POS_LONG : LAST_POS_SHORT;
    assign first_player = lowest_present(cfg.players_present);
    assign turn_norm    = cfg.long_turns ? {cur.turn_hi_hold, cur.turn_lo_hold}
                                         : {cur.turn_lo_hold, 8'h00};

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        res  = '0;
        priority if (cur.pos == 3'd0 && data_byte == END_MARKER)
        begin
            // end marker at record start
            emit       = 1'b1;
            res.kind   = KIND_END_MARKER;
            nxt.pos    = 3'd0;
            nxt.player = first_player;
        end
        else if (cur.pos >= last_pos)
        begin
            // final byte: record complete
            emit       = 1'b1;
            res.kind   = end_of_data ? KIND_RECORD_END : KIND_RECORD;
            res.player = cur.player;
            if (cfg.swapped_layout)
            begin
                res.forward_move = cur.side_hold;
                res.side_move    = cfg.long_turns ? 8'h00 : cur.turn_lo_hold;
                res.turn_amount  = {data_byte, 8'h00};
                res.button_bits  = cur.fwd_hold;
            end
            else
            begin
                res.forward_move = cur.fwd_hold;
                res.side_move    = cur.side_hold;
                res.turn_amount  = turn_norm;
                res.button_bits  = data_byte;
            end
            nxt.pos    = 3'd0;
            nxt.player = end_of_data ? first_player
                                     : next_present(cur.player, cfg.players_present);
        end
        else
        begin
            // capture byte into its hold slot
            unique case (cur.pos)
                3'd0:    nxt.fwd_hold     = data_byte;
                3'd1:    nxt.side_hold    = data_byte;
                3'd2:    nxt.turn_lo_hold = data_byte;
                default: nxt.turn_hi_hold = data_byte;
            endcase
            if (end_of_data)
            begin
                emit       = 1'b1;
                res.kind   = KIND_DROPPED;
                nxt.pos    = 3'd0;
                nxt.player = first_player;
            end
            else
            begin
                nxt.pos = cur.pos + 3'd1;
            end
        end
    end

endmodule

>>> sv/rcrp_out_stage.sv
// Output register stage: holds one result beat until the sink takes it.
module rcrp_out_stage
    import rcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  rcrp_result_t load_res,
    output logic         free,
    rcrp_out_if.source   out_ch
);

    logic         valid_reg;
    logic         valid_next;
    rcrp_result_t res_reg;

    // stage can take a new beat when empty or draining this cycle
    assign free       = !valid_reg || out_ch.ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.kind         = res_reg.kind;
    assign out_ch.player       = res_reg.player;
    assign out_ch.forward_move = res_reg.forward_move;
    assign out_ch.side_move    = res_reg.side_move;
    assign out_ch.turn_amount  = res_reg.turn_amount;
    assign out_ch.button_bits  = res_reg.button_bits;

endmodule
